/* hw/rtl/rlcm_pkg.sv */
package rlcm_pkg;

  // field and datapath widths
  localparam int unsigned ValueW = 31;
  localparam int unsigned LcmW   = 32;
  localparam int unsigned ShiftW = 5;

  // saturation value and list start value
  localparam logic [LcmW-1:0] LcmMax = {LcmW{1'b1}};
  localparam logic [LcmW-1:0] LcmOne = {{(LcmW-1){1'b0}}, 1'b1};

  // last step counts of the bit-serial divide and multiply
  localparam logic [ShiftW-1:0] DivLast = ShiftW'(LcmW - 1);
  localparam logic [ShiftW-1:0] MulLast = ShiftW'(ValueW - 1);

  // sequencer states, one-hot
  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_GCD  = 6'b000010,
    ST_SHL  = 6'b000100,
    ST_DIV  = 6'b001000,
    ST_MUL  = 6'b010000,
    ST_FIN  = 6'b100000
  } state_t;

endpackage

/* hw/rtl/running_lcm_reducer.sv */
// sequence: a zero value, or any value after overflow, goes straight to commit;
//   otherwise binary gcd steps, restore shifts, restoring divide steps and
//   shift-add multiply steps run in turn, then commit; a result stall holds the commit
// throughput: one transaction at a time; the shared one-bit-a-cycle gcd,
//   divide and shift-add multiply sequence sets the rate
// reset: synchronous active-low rst_n, running lcm returns to 1, flag cleared
module running_lcm_reducer
  import rlcm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [ValueW-1:0] in_value,
  input  logic              in_last,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [LcmW-1:0]   out_lcm,
  output logic              out_overflow
);

  state_t state_r, state_nxt;

  logic [LcmW-1:0]   acc_r, acc_nxt;
  logic              ovf_r, ovf_nxt;
  logic              last_r, last_nxt;
  logic              upd_r, upd_nxt;
  logic [LcmW-1:0]   a_r, a_nxt;
  logic [LcmW-1:0]   b_r, b_nxt;
  logic [ShiftW-1:0] k_r, k_nxt;
  logic [ShiftW-1:0] cnt_r, cnt_nxt;
  logic [LcmW-1:0]   rem_r, rem_nxt;
  logic [LcmW-1:0]   q_r, q_nxt;
  logic [ValueW-1:0] mv_r, mv_nxt;
  logic [LcmW:0]     hi_r, hi_nxt;
  logic [ValueW-1:0] lo_r, lo_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [LcmW-1:0]   out_lcm_r, out_lcm_nxt;
  logic              out_ovf_r, out_ovf_nxt;

  // datapath helpers
  logic [LcmW:0]   div_sh;
  logic [LcmW:0]   div_diff;
  logic [LcmW:0]   mul_sum;
  logic [LcmW-1:0] a_minus_b;
  logic [LcmW-1:0] b_minus_a;
  logic [LcmW-1:0] eff_acc;
  logic            eff_ovf;

  assign div_sh    = {rem_r, q_r[LcmW-1]};
  assign div_diff  = div_sh - {1'b0, a_r};
  assign mul_sum   = hi_r + (mv_r[0] ? {1'b0, q_r} : '0);
  assign a_minus_b = a_r - b_r;
  assign b_minus_a = b_r - a_r;

  // fold the product into the running value, saturating past 32 bits
  always_comb begin
    eff_acc = acc_r;
    eff_ovf = ovf_r;
    if (upd_r) begin
      if (hi_r[LcmW:1] != '0) begin
        eff_acc = LcmMax;
        eff_ovf = 1'b1;
      end else begin
        eff_acc = {hi_r[0], lo_r};
      end
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    ovf_nxt       = ovf_r;
    last_nxt      = last_r;
    upd_nxt       = upd_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    k_nxt         = k_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    mv_nxt        = mv_r;
    hi_nxt        = hi_r;
    lo_nxt        = lo_r;
    out_valid_nxt = out_valid_r;
    out_lcm_nxt   = out_lcm_r;
    out_ovf_nxt   = out_ovf_r;

    // result transaction taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          last_nxt = in_last;
          if (in_value == '0 || ovf_r) begin
            upd_nxt   = 1'b0;
            state_nxt = ST_FIN;
          end else begin
            upd_nxt   = 1'b1;
            a_nxt     = acc_r;
            b_nxt     = {1'b0, in_value};
            mv_nxt    = in_value;
            k_nxt     = '0;
            state_nxt = ST_GCD;
          end
        end
      end
      // binary gcd, one step a cycle
      ST_GCD: begin
        priority if (a_r == b_r) begin
          state_nxt = ST_SHL;
        end else if (!a_r[0] && !b_r[0]) begin
          a_nxt = a_r >> 1;
          b_nxt = b_r >> 1;
          k_nxt = k_r + 1'b1;
        end else if (!a_r[0]) begin
          a_nxt = a_r >> 1;
        end else if (!b_r[0]) begin
          b_nxt = b_r >> 1;
        end else if (a_r > b_r) begin
          a_nxt = a_minus_b >> 1;
        end else begin
          b_nxt = b_minus_a >> 1;
        end
      end
      // restore the common power of two, one bit a cycle
      ST_SHL: begin
        if (k_r != '0) begin
          a_nxt = a_r << 1;
          k_nxt = k_r - 1'b1;
        end else begin
          rem_nxt   = '0;
          q_nxt     = acc_r;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      // restoring divide acc / gcd, one quotient bit a cycle
      ST_DIV: begin
        if (!div_diff[LcmW]) begin
          rem_nxt = div_diff[LcmW-1:0];
          q_nxt   = {q_r[LcmW-2:0], 1'b1};
        end else begin
          rem_nxt = div_sh[LcmW-1:0];
          q_nxt   = {q_r[LcmW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DivLast) begin
          hi_nxt    = '0;
          lo_nxt    = '0;
          cnt_nxt   = '0;
          state_nxt = ST_MUL;
        end
      end
      // shift-add multiply quotient * value, one value bit a cycle
      ST_MUL: begin
        hi_nxt  = mul_sum >> 1;
        lo_nxt  = {mul_sum[0], lo_r[ValueW-1:1]};
        mv_nxt  = mv_r >> 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == MulLast) begin
          state_nxt = ST_FIN;
        end
      end
      // commit, and emit at list end once the output register is free
      ST_FIN: begin
        if (!last_r) begin
          acc_nxt   = eff_acc;
          ovf_nxt   = eff_ovf;
          state_nxt = ST_IDLE;
        end else if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_lcm_nxt   = eff_acc;
          out_ovf_nxt   = eff_ovf;
          acc_nxt       = LcmOne;
          ovf_nxt       = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      acc_r       <= LcmOne;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    last_r    <= last_nxt;
    upd_r     <= upd_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    k_r       <= k_nxt;
    cnt_r     <= cnt_nxt;
    rem_r     <= rem_nxt;
    q_r       <= q_nxt;
    mv_r      <= mv_nxt;
    hi_r      <= hi_nxt;
    lo_r      <= lo_nxt;
    out_lcm_r <= out_lcm_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

  assign in_ready     = (state_r == ST_IDLE);
  assign out_valid    = out_valid_r;
  assign out_lcm      = out_lcm_r;
  assign out_overflow = out_ovf_r;

  // running value never drops to zero
  assert property (@(posedge clk) disable iff (!rst_n) acc_r != '0)
    else $error("running lcm is zero");

  // a set overflow flag pins the running value at saturation
  assert property (@(posedge clk) disable iff (!rst_n) ovf_r |-> acc_r == LcmMax)
    else $error("overflow flag without saturated value");

  // gcd operands stay nonzero
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_GCD |-> (a_r != '0 && b_r != '0))
    else $error("gcd operand is zero");

  // divisor is nonzero while dividing
  assert property (@(posedge clk) disable iff (!rst_n) state_r == ST_DIV |-> a_r != '0)
    else $error("divide by zero");

  // a pending result is not overwritten before it is taken
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_lcm_r)))
    else $error("pending result lost");

endmodule
